@@ src/bdq_pkg.sv @@
// shared types and constants for the bounded deque with index read
package bdq_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 8;
    localparam int CAP_W  = 9;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_REM_HEAD = 3'd2,
        OP_REM_TAIL = 3'd3,
        OP_RD_INDEX = 3'd4,
        OP_RD_HEAD  = 3'd5,
        OP_RD_TAIL  = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_NOP,
        K_INSERT,
        K_REMOVE,
        K_READ_IDX,
        K_READ_END
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               at_head;
        logic [WORD_W-1:0]  word;
        logic [IDX_W-1:0]   index;
    } t_req;

endpackage

@@ src/bdq_front.sv @@
// front end: takes command beats and decodes them into requests
module bdq_front
    import bdq_pkg::*;
(
    input  logic                i_start,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [WORD_W-1:0]   i_element_in,
    input  logic [IDX_W-1:0]    i_index,
    input  logic                i_q_full,
    output logic                o_busy,
    output logic                o_push,
    output t_req                o_req
);

    always_comb begin
        o_req.kind    = K_NOP;
        o_req.at_head = 1'b0;
        o_req.word    = i_element_in;
        o_req.index   = i_index;
        case (t_op'(i_operation))
            OP_INS_HEAD: begin
                o_req.kind    = K_INSERT;
                o_req.at_head = 1'b1;
            end
            OP_INS_TAIL: begin
                o_req.kind    = K_INSERT;
            end
            OP_REM_HEAD: begin
                o_req.kind    = K_REMOVE;
                o_req.at_head = 1'b1;
            end
            OP_REM_TAIL: begin
                o_req.kind    = K_REMOVE;
            end
            OP_RD_INDEX: begin
                o_req.kind    = K_READ_IDX;
            end
            OP_RD_HEAD: begin
                o_req.kind    = K_READ_END;
                o_req.at_head = 1'b1;
            end
            OP_RD_TAIL: begin
                o_req.kind    = K_READ_END;
            end
            default: begin
                o_req.kind    = K_NOP;
            end
        endcase
    end

    assign o_busy = i_q_full;
    assign o_push = i_start & ~i_q_full;

endmodule

@@ src/bdq_queue.sv @@
// two-entry request queue between front and back
module bdq_queue
    import bdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_req    i_req,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_req    o_req
);

    t_req       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

    assign o_full  = r_fill == 2'd2;
    assign o_empty = r_fill == 2'd0;
    assign o_req   = r_slot[r_rd_ptr];

endmodule

@@ src/bdq_back.sv @@
// back end: ring storage, head pointer, count and result registers
module bdq_back
    import bdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic                i_pop,
    input  t_req                i_req,
    output logic                o_done,
    output logic [WORD_W-1:0]   o_element_out,
    output logic [CNT_W-1:0]    o_count,
    output logic [ST_W-1:0]     o_status
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [CAP_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_count;
    t_status           r_out_status;
    logic              r_out_sel_mem;

    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;
    t_status           n_status;
    logic              n_sel_mem;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CAP_W-1:0]  eff_cap;
    logic              is_empty;

    assign eff_cap  = (r_cap > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : r_cap;
    assign is_empty = r_count == '0;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = ST_OK;
        n_sel_mem = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_head + r_count[ADDR_W-1:0];
        rd_en     = 1'b0;
        rd_addr   = r_head;
        case (i_req.kind)
            K_INSERT: begin
                if (CAP_W'(r_count) >= eff_cap) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (i_req.at_head) begin
                        n_head  = r_head - ADDR_W'(1);
                        wr_addr = r_head - ADDR_W'(1);
                    end
                end
            end
            K_REMOVE: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (i_req.at_head) begin
                        n_head = r_head + ADDR_W'(1);
                    end
                end
            end
            K_READ_IDX: begin
                rd_addr = r_head + ADDR_W'(i_req.index);
                if (CNT_W'(i_req.index) < r_count) begin
                    rd_en     = 1'b1;
                    n_sel_mem = 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            K_READ_END: begin
                // tail sits at head + count - 1 around the ring
                if (!i_req.at_head) begin
                    rd_addr = r_head + ADDR_W'(r_count - CNT_W'(1));
                end
                if (is_empty) begin
                    n_status = ST_RANGE;
                end else begin
                    rd_en     = 1'b1;
                    n_sel_mem = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_out_valid <= i_pop;
            if (i_pop) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_out_count   <= n_count;
            r_out_status  <= n_status;
            r_out_sel_mem <= n_sel_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop && wr_en) begin
            r_mem[wr_addr] <= i_req.word;
        end
        if (i_pop && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_done        = r_out_valid;
    assign o_element_out = r_out_sel_mem ? r_rd_data : '0;
    assign o_count       = r_out_count;
    assign o_status      = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above storage depth");

    a_result_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |=> r_out_valid)
        else $error("popped request gave no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pop |=> !r_out_valid)
        else $error("result without a popped request");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> r_count == $past(r_count))
        else $error("rejected insert changed the count");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> !r_out_sel_mem)
        else $error("failed request returned storage data");

endmodule

@@ src/bounded_deque_with_index_read_unit.sv @@
// Bounded double-ended queue of 32-bit words with head/tail insert and remove and
// reads by position from the head. A command beat is taken when i_start is high and
// o_busy is low; it passes the queue slot and the result registers; its result shows
// on o_done for one cycle and cannot be held off. One command is served per cycle: the
// back end finishes each request as it pops it, reads included, since the storage read
// is registered and lands with the result registers. o_busy only rises if the two-entry
// request queue fills, which the back end draining one entry per cycle keeps from
// happening. i_cfg_wdata sets the capacity limit (clamped to the storage depth); write
// it only while no command is in flight. Storage needs no clearing pass after reset.
module bounded_deque_with_index_read_unit
    import bdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [WORD_W-1:0]   i_element_in,
    input  logic [IDX_W-1:0]    i_index,
    output logic                o_done,
    output logic [WORD_W-1:0]   o_element_out,
    output logic [CNT_W-1:0]    o_count,
    output logic [ST_W-1:0]     o_status
);

    t_req front_req;
    t_req back_req;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    bdq_front u_front (
        .i_start      (i_start),
        .i_operation  (i_operation),
        .i_element_in (i_element_in),
        .i_index      (i_index),
        .i_q_full     (q_full),
        .o_busy       (o_busy),
        .o_push       (push),
        .o_req        (front_req)
    );

    bdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_req   (back_req)
    );

    // back end never stalls, so it drains one beat whenever one is queued
    assign pop = ~q_empty;

    bdq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pop         (pop),
        .i_req         (back_req),
        .o_done        (o_done),
        .o_element_out (o_element_out),
        .o_count       (o_count),
        .o_status      (o_status)
    );

endmodule
